// ----- sv/tiew_pkg.sv -----
// Package for the Tomasulo issue/execute/writeback block: types and constants.
// No dependencies.
package tiew_pkg;

    localparam int ADD_STATIONS   = 3;
    localparam int MUL_STATIONS   = 2;
    localparam int LOAD_STATIONS  = 3;
    localparam int STORE_STATIONS = 3;
    localparam int NUM_STATIONS   = ADD_STATIONS + MUL_STATIONS + LOAD_STATIONS + STORE_STATIONS;
    localparam int NUM_REGS       = 32;
    localparam int MUL_BASE       = ADD_STATIONS;
    localparam int LOAD_BASE      = MUL_BASE + MUL_STATIONS;
    localparam int STORE_BASE     = LOAD_BASE + LOAD_STATIONS;

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_MUL   = 3'd2;
    localparam logic [2:0] OP_DIV   = 3'd3;
    localparam logic [2:0] OP_LOAD  = 3'd4;
    localparam logic [2:0] OP_STORE = 3'd5;

    localparam logic [2:0] CFG_ADD   = 3'd0;
    localparam logic [2:0] CFG_MUL   = 3'd1;
    localparam logic [2:0] CFG_DIV   = 3'd2;
    localparam logic [2:0] CFG_LOAD  = 3'd3;
    localparam logic [2:0] CFG_STORE = 3'd4;

    localparam int QDEPTH = 2;

    // One queued tick as seen by the back end
    typedef struct packed {
        logic       kind;
        logic [2:0] op;
        logic [4:0] dest_reg;
        logic [4:0] src_a_reg;
        logic [4:0] src_b_reg;
        logic [4:0] probe_reg;
    } tick_t;

    // Result item of one tick
    typedef struct packed {
        logic        probe_pending;
        logic [31:0] probe_value;
        logic [31:0] bcast_value;
        logic [3:0]  bcast_station;
        logic        bcast_valid;
        logic        issued;
    } result_t;

endpackage

// ----- sv/tomasulo_issue_execute_writeback_top.sv -----
// Top level of the Tomasulo issue/execute/writeback block.
// A tick moves through the back-end states IDLE, TICK, CALC (with DIV while the iterative divider
// runs for each divide computed) and WB; the back end takes a new tick only after WB, and a waiting
// result holds writeback. The two-entry queue in the front end can accept ticks meanwhile.
// Reset: rst_n asynchronous active low clears stations, tags, registers and queue;
// latency registers return to their reset defaults. Depends on tiew_pkg, tiew_front, tiew_back.
module tomasulo_issue_execute_writeback_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // op, dest_reg, src_a_reg, src_b_reg, probe_reg
    input  logic        s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // issued, bcast_valid, bcast_station, bcast_value,
                                       // probe_value, probe_pending
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [5:0]  cfg_data
);
    logic [5:0] lat_add_reg, lat_mul_reg, lat_div_reg, lat_load_reg, lat_store_reg;
    tiew_pkg::tick_t   in_tick, q_tick;
    tiew_pkg::result_t res;
    logic q_valid, q_ready;

    assign cfg_ready = 1'b1;

    // Latency registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_add_reg   <= 6'd2;
            lat_mul_reg   <= 6'd10;
            lat_div_reg   <= 6'd40;
            lat_load_reg  <= 6'd2;
            lat_store_reg <= 6'd1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tiew_pkg::CFG_ADD:   lat_add_reg   <= cfg_data;
                tiew_pkg::CFG_MUL:   lat_mul_reg   <= cfg_data;
                tiew_pkg::CFG_DIV:   lat_div_reg   <= cfg_data;
                tiew_pkg::CFG_LOAD:  lat_load_reg  <= cfg_data;
                tiew_pkg::CFG_STORE: lat_store_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_tick.kind      = s_axis_tuser;
    assign in_tick.op        = s_axis_tdata[2:0];
    assign in_tick.dest_reg  = s_axis_tdata[7:3];
    assign in_tick.src_a_reg = s_axis_tdata[12:8];
    assign in_tick.src_b_reg = s_axis_tdata[17:13];
    assign in_tick.probe_reg = s_axis_tdata[22:18];

    tiew_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_tick  (in_tick),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_tick   (q_tick)
    );

    tiew_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_tick    (q_tick),
        .lat_add   (lat_add_reg),
        .lat_mul   (lat_mul_reg),
        .lat_div   (lat_div_reg),
        .lat_load  (lat_load_reg),
        .lat_store (lat_store_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    assign m_axis_tdata = {1'b0, res.probe_pending, res.probe_value, res.bcast_value,
                           res.bcast_station, res.bcast_valid, res.issued};

`ifndef ASSERT_OFF
    a_idle_station: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[5:2] == 4'd0)
        else $error("station index set without broadcast");
    a_idle_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[37:6] == 32'd0)
        else $error("broadcast value set without broadcast");
    a_station_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[5:2] < 4'd11)
        else $error("station index out of range");
`endif
endmodule

// ----- sv/tiew_front.sv -----
// Front end: accepts ticks from the input stream and queues them.
// Depends on tiew_pkg.
module tiew_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tiew_pkg::tick_t   in_tick,
    output logic              q_valid,
    input  logic              q_ready,
    output tiew_pkg::tick_t   q_tick
);
    tiew_pkg::tick_t mem_reg [tiew_pkg::QDEPTH];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_tick   = mem_reg[rptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // Two-entry queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wptr_reg] <= in_tick;
    end
endmodule

// ----- sv/tiew_div.sv -----
// Iterative signed 32-bit divider, one quotient bit per cycle.
// Depends on nothing.
module tiew_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        done,
    output logic [31:0] q
);
    logic [31:0] rem_reg, quo_reg, den_reg;
    logic [5:0]  cnt_reg;
    logic        neg_reg, busy_reg, special_reg;
    logic [31:0] special_val_reg;
    logic [32:0] trial;

    assign trial = {rem_reg, quo_reg[31]} - {1'b0, den_reg};
    assign done  = !busy_reg;
    assign q     = special_reg ? special_val_reg : (neg_reg ? -quo_reg : quo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 6'd32;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) busy_reg <= 1'b0;
        end
    end

    // Restoring division on magnitudes
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= 32'd0;
            quo_reg <= a[31] ? -a : a;
            den_reg <= b[31] ? -b : b;
            neg_reg <= a[31] ^ b[31];
            special_reg <= (b == 32'd0) || (a == 32'h8000_0000 && b == 32'hFFFF_FFFF);
            special_val_reg <= (b == 32'd0) ? 32'd0 : 32'h8000_0000;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_reg <= trial[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[30:0], quo_reg[31]};
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end
endmodule

// ----- sv/tiew_back.sv -----
// Back end: stations, register file, issue/execute/writeback for one tick.
// Depends on tiew_pkg and tiew_div.
module tiew_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  tiew_pkg::tick_t    q_tick,
    input  logic [5:0]         lat_add,
    input  logic [5:0]         lat_mul,
    input  logic [5:0]         lat_div,
    input  logic [5:0]         lat_load,
    input  logic [5:0]         lat_store,
    output logic               out_valid,
    input  logic               out_ready,
    output tiew_pkg::result_t  out_res
);
    localparam int NS = tiew_pkg::NUM_STATIONS;
    localparam int NR = tiew_pkg::NUM_REGS;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_TICK = 5'b00010,
        ST_CALC = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_WB   = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic        busy_reg [NS];
    logic [2:0]  op_reg   [NS];
    logic [31:0] jv_reg   [NS];
    logic [31:0] kv_reg   [NS];
    logic [3:0]  jt_reg   [NS];
    logic [3:0]  kt_reg   [NS];
    logic [5:0]  cyc_reg  [NS];
    logic [31:0] res_reg  [NS];
    logic [31:0] rv_reg   [NR];
    logic [3:0]  rt_reg   [NR];

    tiew_pkg::tick_t   tick_reg;
    tiew_pkg::result_t res_out_reg;
    logic        out_valid_reg;
    logic        issued_reg;
    logic [3:0]  calc_idx_reg;
    logic        calc_need;
    logic        calc_div;
    logic        calc_last;
    logic [31:0] prod;
    logic        div_start;
    logic        div_done;
    logic [31:0] div_q;
    logic        wb_go;

    // Per-tick combinational views
    logic        iss_ok;
    logic [3:0]  iss_idx;
    logic [5:0]  iss_lat;
    int          lo, hi;
    logic        wb2_any;
    logic [3:0]  wb2_idx;
    logic        ex_rdy  [NS];
    logic [5:0]  cyc_new [NS];
    logic [31:0] res_new [NS];
    logic [31:0] bval;
    logic        probe_hit;

    assign q_ready   = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_res   = res_out_reg;
    assign wb_go     = (state_reg == ST_WB) && (!out_valid_reg || out_ready);

    // Issue slot search
    always_comb
    begin
        lo = 0; hi = 0; iss_lat = lat_add;
        iss_ok = 1'b0; iss_idx = 4'd0;
        unique case (tick_reg.op)
            tiew_pkg::OP_ADD, tiew_pkg::OP_SUB:
            begin
                lo = 0; hi = tiew_pkg::MUL_BASE; iss_lat = lat_add;
            end
            tiew_pkg::OP_MUL:
            begin
                lo = tiew_pkg::MUL_BASE; hi = tiew_pkg::LOAD_BASE; iss_lat = lat_mul;
            end
            tiew_pkg::OP_DIV:
            begin
                lo = tiew_pkg::MUL_BASE; hi = tiew_pkg::LOAD_BASE; iss_lat = lat_div;
            end
            tiew_pkg::OP_LOAD:
            begin
                lo = tiew_pkg::LOAD_BASE; hi = tiew_pkg::STORE_BASE; iss_lat = lat_load;
            end
            tiew_pkg::OP_STORE:
            begin
                lo = tiew_pkg::STORE_BASE; hi = NS; iss_lat = lat_store;
            end
            default:
            begin
                lo = 0; hi = 0;
            end
        endcase
        for (int i = NS - 1; i >= 0; i--)
        begin
            if (i >= lo && i < hi && !busy_reg[i] && tick_reg.kind)
            begin
                iss_ok = 1'b1; iss_idx = 4'(i);
            end
        end
    end

    // Execute view on post-issue state: countdown, add/sub/address results, winner
    always_comb
    begin
        wb2_any = 1'b0; wb2_idx = 4'd0; bval = 32'd0;
        for (int i = 0; i < NS; i++)
        begin
            ex_rdy[i]  = busy_reg[i] && jt_reg[i] == 4'd0 && kt_reg[i] == 4'd0;
            cyc_new[i] = (ex_rdy[i] && cyc_reg[i] != 6'd0) ? cyc_reg[i] - 6'd1 : cyc_reg[i];
            res_new[i] = res_reg[i];
            if (ex_rdy[i] && cyc_new[i] == 6'd0)
            begin
                unique case (op_reg[i])
                    tiew_pkg::OP_SUB: res_new[i] = jv_reg[i] - kv_reg[i];
                    tiew_pkg::OP_MUL: res_new[i] = res_reg[i];
                    tiew_pkg::OP_DIV: res_new[i] = res_reg[i];
                    default:          res_new[i] = jv_reg[i] + kv_reg[i];
                endcase
            end
        end
        for (int i = NS - 1; i >= 0; i--)
        begin
            if (ex_rdy[i] && cyc_new[i] == 6'd0)
            begin
                wb2_any = 1'b1; wb2_idx = 4'(i);
            end
        end
        bval = res_new[wb2_idx];
    end

    assign probe_hit = wb2_any && (rt_reg[tick_reg.probe_reg] == wb2_idx + 4'd1);

    // Visits one mul/div station per cycle unless dividing; finishers get results
    assign calc_need = ex_rdy[calc_idx_reg] && (cyc_reg[calc_idx_reg] <= 6'd1);
    assign calc_div  = calc_need && (op_reg[calc_idx_reg] == tiew_pkg::OP_DIV);
    assign calc_last = (calc_idx_reg == 4'(tiew_pkg::LOAD_BASE - 1));
    assign prod      = jv_reg[calc_idx_reg] * kv_reg[calc_idx_reg];

    tiew_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .a     (jv_reg[calc_idx_reg]),
        .b     (kv_reg[calc_idx_reg]),
        .done  (div_done),
        .q     (div_q)
    );

    // Sequencer: IDLE latches tick, TICK issues, CALC/DIV fill mul/div results,
    // WB does execute + writeback and forms the result.
    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE: if (q_valid) state_next = ST_TICK;
            ST_TICK: state_next = ST_CALC;
            ST_CALC:
            begin
                if (calc_div)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else if (calc_last)
                    state_next = ST_WB;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = calc_last ? ST_WB : ST_CALC;
            end
            ST_WB:   if (wb_go) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NS; i++)
            begin
                busy_reg[i] <= 1'b0;
                jt_reg[i]   <= 4'd0;
                kt_reg[i]   <= 4'd0;
            end
            for (int r = 0; r < NR; r++)
            begin
                rt_reg[r] <= 4'd0;
                rv_reg[r] <= 32'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (wb_go)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_TICK && iss_ok)
            begin
                busy_reg[iss_idx] <= 1'b1;
                jt_reg[iss_idx] <= rt_reg[tick_reg.src_a_reg];
                kt_reg[iss_idx] <= rt_reg[tick_reg.src_b_reg];
                if (tick_reg.op != tiew_pkg::OP_STORE)
                    rt_reg[tick_reg.dest_reg] <= iss_idx + 4'd1;
            end
            if (wb_go && wb2_any)
            begin
                busy_reg[wb2_idx] <= 1'b0;
                for (int j = 0; j < NS; j++)
                begin
                    if (busy_reg[j] && jt_reg[j] == wb2_idx + 4'd1) jt_reg[j] <= 4'd0;
                    if (busy_reg[j] && kt_reg[j] == wb2_idx + 4'd1) kt_reg[j] <= 4'd0;
                end
                for (int r = 0; r < NR; r++)
                begin
                    if (rt_reg[r] == wb2_idx + 4'd1)
                    begin
                        rt_reg[r] <= 4'd0;
                        rv_reg[r] <= bval;
                    end
                end
            end
        end
    end

    // Payload side
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid) tick_reg <= q_tick;
            end
            ST_TICK:
            begin
                issued_reg   <= iss_ok;
                calc_idx_reg <= 4'(tiew_pkg::MUL_BASE);
                if (iss_ok)
                begin
                    op_reg[iss_idx]  <= tick_reg.op;
                    cyc_reg[iss_idx] <= iss_lat;
                    if (rt_reg[tick_reg.src_a_reg] == 4'd0)
                        jv_reg[iss_idx] <= rv_reg[tick_reg.src_a_reg];
                    if (rt_reg[tick_reg.src_b_reg] == 4'd0)
                        kv_reg[iss_idx] <= rv_reg[tick_reg.src_b_reg];
                end
            end
            ST_CALC:
            begin
                if (calc_need && op_reg[calc_idx_reg] == tiew_pkg::OP_MUL)
                    res_reg[calc_idx_reg] <= prod;
                if (!calc_div) calc_idx_reg <= calc_idx_reg + 4'd1;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    res_reg[calc_idx_reg] <= div_q;
                    calc_idx_reg <= calc_idx_reg + 4'd1;
                end
            end
            ST_WB:
            begin
                if (wb_go)
                begin
                    for (int i = 0; i < NS; i++)
                    begin
                        cyc_reg[i] <= cyc_new[i];
                        res_reg[i] <= res_new[i];
                    end
                    if (wb2_any)
                    begin
                        op_reg[wb2_idx] <= tiew_pkg::OP_ADD;
                        for (int j = 0; j < NS; j++)
                        begin
                            if (busy_reg[j] && jt_reg[j] == wb2_idx + 4'd1) jv_reg[j] <= bval;
                            if (busy_reg[j] && kt_reg[j] == wb2_idx + 4'd1) kv_reg[j] <= bval;
                        end
                    end
                    res_out_reg.issued        <= issued_reg;
                    res_out_reg.bcast_valid   <= wb2_any;
                    res_out_reg.bcast_station <= wb2_any ? wb2_idx : 4'd0;
                    res_out_reg.bcast_value   <= wb2_any ? bval : 32'd0;
                    res_out_reg.probe_value   <= probe_hit ? bval : rv_reg[tick_reg.probe_reg];
                    res_out_reg.probe_pending <= (rt_reg[tick_reg.probe_reg] != 4'd0) &&
                                                 !probe_hit;
                end
            end
            default: ;
        endcase
    end
endmodule

// ----- tb/tomasulo_issue_execute_writeback_top_tb.sv -----
// Testbench for the Tomasulo issue/execute/writeback top level.
// Streams ticks through the block and checks every result against an in-bench scoreboard
// model or, for directed rows, a typed-in expectation. Depends on tiew_pkg and tomasulo_issue_execute_writeback_top.
`timescale 1ns / 100ps

module tomasulo_issue_execute_writeback_top_tb;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic        kind;
        logic [2:0]  op;
        logic [4:0]  rd;
        logic [4:0]  ra;
        logic [4:0]  rb;
        logic [4:0]  pr;
    } tick_in_t;

    typedef struct {
        logic        issued;
        logic        bv;
        logic [3:0]  bstation;
        logic [31:0] bvalue;
        logic [31:0] pvalue;
        logic        ppending;
    } tick_out_t;

    // Directed row: stimulus plus optional typed-in expectation
    typedef struct {
        tick_in_t  stim;
        bit        fixed;
        tick_out_t want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // op, dest_reg, src_a_reg, src_b_reg, probe_reg
    logic        s_axis_tuser;   // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;   // issued, bcast_valid, bcast_station, bcast_value,
                                 // probe_value, probe_pending
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [5:0]  cfg_data;

    tomasulo_issue_execute_writeback_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Scoreboard copy of the machine
    logic [5:0]  lat_q [5];
    logic        rs_busy [tiew_pkg::NUM_STATIONS];
    logic [2:0]  rs_op [tiew_pkg::NUM_STATIONS];
    logic [31:0] rs_vj [tiew_pkg::NUM_STATIONS];
    logic [31:0] rs_vk [tiew_pkg::NUM_STATIONS];
    logic [3:0]  rs_qj [tiew_pkg::NUM_STATIONS];
    logic [3:0]  rs_qk [tiew_pkg::NUM_STATIONS];
    logic [5:0]  rs_left [tiew_pkg::NUM_STATIONS];
    logic [31:0] rs_res [tiew_pkg::NUM_STATIONS];
    logic [31:0] rf_value [tiew_pkg::NUM_REGS];
    logic [3:0]  rf_tag [tiew_pkg::NUM_REGS];

    tick_out_t   pending_results [$];
    int          errors;
    int          sent;
    int          checked;
    int          bcasts;
    int          cycles;
    int          src_idle_pct;
    int          snk_idle_pct;
    bit          draining;

    function automatic logic [31:0] alu_result(logic [2:0] op, logic [31:0] a, logic [31:0] b);
        case (op)
            tiew_pkg::OP_SUB: return a - b;
            tiew_pkg::OP_MUL: return a * b;
            tiew_pkg::OP_DIV:
            begin
                if (b == 32'd0)
                    return 32'd0;
                if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
                    return 32'h8000_0000;
                return $signed(a) / $signed(b);
            end
            default: return a + b;
        endcase
    endfunction

    // Advance the model by one tick and return the expected result
    function automatic tick_out_t model_tick(tick_in_t t);
        tick_out_t o;
        int lo;
        int hi;
        int s;
        logic [5:0] lat;
        logic [3:0] tag;
        logic [31:0] v;
        o = '{default: '0};
        lo = 0;
        hi = 0;
        s = -1;
        lat = '0;
        if (t.kind)
        begin
            case (t.op)
                tiew_pkg::OP_ADD, tiew_pkg::OP_SUB:
                begin
                    lo = 0; hi = tiew_pkg::MUL_BASE; lat = lat_q[tiew_pkg::CFG_ADD];
                end
                tiew_pkg::OP_MUL:
                begin
                    lo = tiew_pkg::MUL_BASE; hi = tiew_pkg::LOAD_BASE;
                    lat = lat_q[tiew_pkg::CFG_MUL];
                end
                tiew_pkg::OP_DIV:
                begin
                    lo = tiew_pkg::MUL_BASE; hi = tiew_pkg::LOAD_BASE;
                    lat = lat_q[tiew_pkg::CFG_DIV];
                end
                tiew_pkg::OP_LOAD:
                begin
                    lo = tiew_pkg::LOAD_BASE; hi = tiew_pkg::STORE_BASE;
                    lat = lat_q[tiew_pkg::CFG_LOAD];
                end
                tiew_pkg::OP_STORE:
                begin
                    lo = tiew_pkg::STORE_BASE; hi = tiew_pkg::NUM_STATIONS;
                    lat = lat_q[tiew_pkg::CFG_STORE];
                end
                default:  begin lo = 0; hi = 0; end
            endcase
            for (int i = lo; i < hi; i++)
                if (s < 0 && !rs_busy[i])
                    s = i;
            if (s >= 0)
            begin
                o.issued = 1'b1;
                rs_busy[s] = 1'b1;
                rs_op[s] = t.op;
                rs_qj[s] = rf_tag[t.ra];
                if (rf_tag[t.ra] == 0)
                    rs_vj[s] = rf_value[t.ra];
                rs_qk[s] = rf_tag[t.rb];
                if (rf_tag[t.rb] == 0)
                    rs_vk[s] = rf_value[t.rb];
                if (t.op != tiew_pkg::OP_STORE)
                    rf_tag[t.rd] = 4'(s + 1);
                rs_left[s] = lat;
            end
        end
        // execute
        for (int i = 0; i < tiew_pkg::NUM_STATIONS; i++)
        begin
            if (rs_busy[i] && rs_qj[i] == 0 && rs_qk[i] == 0)
            begin
                if (rs_left[i] > 0)
                    rs_left[i]--;
                if (rs_left[i] == 0)
                    rs_res[i] = alu_result(rs_op[i], rs_vj[i], rs_vk[i]);
            end
        end
        // write back: lowest finished station
        for (int i = 0; i < tiew_pkg::NUM_STATIONS; i++)
        begin
            if (!o.bv && rs_busy[i] && rs_qj[i] == 0 && rs_qk[i] == 0 && rs_left[i] == 0)
            begin
                tag = 4'(i + 1);
                v = rs_res[i];
                for (int j = 0; j < tiew_pkg::NUM_STATIONS; j++)
                begin
                    if (rs_busy[j] && rs_qj[j] == tag) begin rs_vj[j] = v; rs_qj[j] = '0; end
                    if (rs_busy[j] && rs_qk[j] == tag) begin rs_vk[j] = v; rs_qk[j] = '0; end
                end
                for (int j = 0; j < tiew_pkg::NUM_REGS; j++)
                    if (rf_tag[j] == tag) begin rf_value[j] = v; rf_tag[j] = '0; end
                rs_busy[i] = 1'b0;
                rs_op[i] = '0;
                o.bv = 1'b1;
                o.bstation = 4'(i);
                o.bvalue = v;
            end
        end
        o.pvalue = rf_value[t.pr];
        o.ppending = (rf_tag[t.pr] != 0);
        return o;
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Output side: random stall and compare
    always @(posedge clk)
    begin
        tick_out_t w;
        tick_out_t g;
        if (m_axis_tvalid && m_axis_tready)
        begin
            g.issued   = m_axis_tdata[0];
            g.bv       = m_axis_tdata[1];
            g.bstation = m_axis_tdata[5:2];
            g.bvalue   = m_axis_tdata[37:6];
            g.pvalue   = m_axis_tdata[69:38];
            g.ppending = m_axis_tdata[70];
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transfer");
                errors++;
            end
            else
            begin
                w = pending_results.pop_front();
                checked++;
                if (g.bv)
                    bcasts++;
                if (g.issued !== w.issued)
                begin
                    $error("issued: expected %0h got %0h", w.issued, g.issued); errors++;
                end
                if (g.bv !== w.bv)
                begin
                    $error("bcast_valid: expected %0h got %0h", w.bv, g.bv); errors++;
                end
                if (g.bstation !== w.bstation)
                begin
                    $error("bcast_station: expected %0d got %0d", w.bstation, g.bstation);
                    errors++;
                end
                if (g.bvalue !== w.bvalue)
                begin
                    $error("bcast_value: expected %0h got %0h", w.bvalue, g.bvalue); errors++;
                end
                if (g.pvalue !== w.pvalue)
                begin
                    $error("probe_value: expected %0h got %0h", w.pvalue, g.pvalue); errors++;
                end
                if (g.ppending !== w.ppending)
                begin
                    $error("probe_pending: expected %0h got %0h", w.ppending, g.ppending);
                    errors++;
                end
            end
        end
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= draining || ($urandom_range(99) >= snk_idle_pct);
    end

    // Leaves tvalid high after the transfer; the next call reuses or drops it, or the caller drops it
    task automatic send_tick(tick_in_t t, bit fixed, tick_out_t want);
        tick_out_t p;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= t.kind;
        s_axis_tdata  <= {3'b0, t.pr, t.rb, t.ra, t.rd, t.op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        p = model_tick(t);
        pending_results.push_back(fixed ? want : p);
        sent++;
    endtask

    task automatic wait_empty();
        int n;
        n = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // the block can still hold busy stations after its last result; small margin anyway
        while (n < 8)
        begin
            @(posedge clk);
            n++;
        end
    endtask

    task automatic write_latency(logic [2:0] idx, logic [5:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        lat_q[idx] = val;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic tick_in_t random_tick(int mode);
        tick_in_t t;
        t = tick_in_t'(24'($urandom));
        t.kind = ($urandom_range(99) < 70);
        if ($urandom_range(99) < 95)
            t.op = 3'($urandom_range(5));
        // mostly a small register window so dependencies chain
        if (mode == 0)
        begin
            t.rd = 5'($urandom_range(7));
            t.ra = 5'($urandom_range(7));
            t.rb = 5'($urandom_range(7));
            t.pr = 5'($urandom_range(7));
        end
        return t;
    endfunction

    task automatic random_phase(int count);
        tick_out_t none;
        none = '{default: '0};
        for (int i = 0; i < count; i++)
            send_tick(random_tick($urandom_range(3) == 0), 1'b0, none);
    endtask

    initial
    begin
        row_t rows [$];
        row_t r;
        tick_out_t z;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0; sent = 0; checked = 0; bcasts = 0;
        draining = 1'b0;
        src_idle_pct = 34;
        snk_idle_pct = 63;
        lat_q[tiew_pkg::CFG_ADD] = 6'd2; lat_q[tiew_pkg::CFG_MUL] = 6'd10;
        lat_q[tiew_pkg::CFG_DIV] = 6'd40; lat_q[tiew_pkg::CFG_LOAD] = 6'd2;
        lat_q[tiew_pkg::CFG_STORE] = 6'd1;
        for (int i = 0; i < tiew_pkg::NUM_STATIONS; i++)
        begin
            rs_busy[i] = 0; rs_op[i] = 0; rs_vj[i] = 0; rs_vk[i] = 0;
            rs_qj[i] = 0; rs_qk[i] = 0; rs_left[i] = 0; rs_res[i] = 0;
        end
        for (int i = 0; i < tiew_pkg::NUM_REGS; i++)
        begin
            rf_value[i] = 0; rf_tag[i] = 0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        z = '{default: '0};
        // plain tick after reset: everything zero
        r.stim = '{1'b0, tiew_pkg::OP_ADD, 5'd0, 5'd0, 5'd0, 5'd31}; r.fixed = 1; r.want = z;
        rows.push_back(r);
        // unknown opcodes do not issue
        r.stim = '{1'b1, 3'd6, 5'd1, 5'd2, 5'd3, 5'd1}; rows.push_back(r);
        r.stim = '{1'b1, 3'd7, 5'd31, 5'd31, 5'd31, 5'd31}; rows.push_back(r);
        // add issues into station 0, renames r1
        r.stim = '{1'b1, tiew_pkg::OP_ADD, 5'd1, 5'd0, 5'd0, 5'd1}; r.fixed = 1;
        r.want = '{1'b1, 1'b0, 4'd0, 32'd0, 32'd0, 1'b1}; rows.push_back(r);
        r.fixed = 0;
        r.stim = '{1'b1, tiew_pkg::OP_SUB, 5'd2, 5'd1, 5'd1, 5'd2}; rows.push_back(r);
        r.stim = '{1'b1, tiew_pkg::OP_ADD, 5'd3, 5'd3, 5'd3, 5'd3}; rows.push_back(r);
        r.stim = '{1'b1, tiew_pkg::OP_ADD, 5'd4, 5'd0, 5'd0, 5'd4}; rows.push_back(r);
        r.stim = '{1'b1, tiew_pkg::OP_MUL, 5'd5, 5'd2, 5'd3, 5'd5}; rows.push_back(r);
        r.stim = '{1'b1, tiew_pkg::OP_DIV, 5'd6, 5'd5, 5'd0, 5'd6}; rows.push_back(r);
        r.stim = '{1'b1, tiew_pkg::OP_MUL, 5'd7, 5'd1, 5'd1, 5'd7}; rows.push_back(r);
        r.stim = '{1'b1, tiew_pkg::OP_LOAD, 5'd8, 5'd31, 5'd0, 5'd8}; rows.push_back(r);
        r.stim = '{1'b1, tiew_pkg::OP_LOAD, 5'd9, 5'd8, 5'd8, 5'd9}; rows.push_back(r);
        r.stim = '{1'b1, tiew_pkg::OP_LOAD, 5'd10, 5'd0, 5'd31, 5'd10}; rows.push_back(r);
        r.stim = '{1'b1, tiew_pkg::OP_LOAD, 5'd11, 5'd0, 5'd0, 5'd11}; rows.push_back(r);
        r.stim = '{1'b1, tiew_pkg::OP_STORE, 5'd12, 5'd9, 5'd10, 5'd12}; rows.push_back(r);
        r.stim = '{1'b1, tiew_pkg::OP_STORE, 5'd31, 5'd31, 5'd31, 5'd31}; rows.push_back(r);
        r.stim = '{1'b1, tiew_pkg::OP_STORE, 5'd0, 5'd0, 5'd0, 5'd0}; rows.push_back(r);
        r.stim = '{1'b1, tiew_pkg::OP_STORE, 5'd0, 5'd0, 5'd0, 5'd0}; rows.push_back(r);
        for (int i = 0; i < 6; i++)
        begin
            r.stim = '{1'b0, 3'd7, 5'd31, 5'd31, 5'd31, 5'($urandom_range(12))};
            rows.push_back(r);
        end
        foreach (rows[i])
            send_tick(rows[i].stim, rows[i].fixed, rows[i].want);
        wait_empty();

        // All latencies at zero, then at one
        for (int i = 0; i < 5; i++)
            write_latency(3'(i), 6'd0);
        random_phase(300);
        wait_empty();
        for (int i = 0; i < 5; i++)
            write_latency(3'(i), 6'd1);
        random_phase(300);
        // hold off the sender until everything is back
        wait_empty();
        write_latency(tiew_pkg::CFG_ADD, 6'd63); write_latency(tiew_pkg::CFG_MUL, 6'd63);
        write_latency(tiew_pkg::CFG_DIV, 6'd63); write_latency(tiew_pkg::CFG_LOAD, 6'd63);
        write_latency(tiew_pkg::CFG_STORE, 6'd63);
        src_idle_pct = 63;
        snk_idle_pct = 34;
        random_phase(250);
        wait_empty();
        for (int i = 0; i < 5; i++)
            write_latency(3'(i), 6'($urandom_range(1, 6)));
        src_idle_pct = 0;
        snk_idle_pct = 0;
        random_phase(850);

        s_axis_tvalid <= 1'b0;
        draining = 1'b1;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d ticks, %0d results checked, %0d broadcasts seen",
                 sent, checked, bcasts);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- tomasulo_issue_execute_writeback_top.f -----
sv/tiew_pkg.sv
sv/tiew_front.sv
sv/tiew_div.sv
sv/tiew_back.sv
sv/tomasulo_issue_execute_writeback_top.sv
tb/tomasulo_issue_execute_writeback_top_tb.sv
